// ===== hdl/bll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_pkg - shared types and codes of the linked list engine
// Command codes, result status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bll_pkg;

   // Command codes carried in the low bits of req_tdata
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_LIST   = 2'd3
   } cmd_type;

   // Result status codes carried on rsp_tuser
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_LISTED   = 3'd4;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ALLOC = 6'b000010,
      S_WALK  = 6'b000100,
      S_FREE  = 6'b001000,
      S_LIST  = 6'b010000,
      S_REPLY = 6'b100000
   } state_type;

endpackage

// ===== hdl/bll_link_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_link_store - next-slot link memory
// One write and one registered read per cycle. A slot whose link was never
// written reads as the following slot, the last slot wrapping to slot zero.
// ----------------------------------------------------------------------------
module bll_link_store #(
   parameter int CAPACITY = 32,
   parameter int SW       = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_addr,
   input  logic [SW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [SW-1:0] rd_addr,
   output logic [SW-1:0] rd_data
);

   localparam logic [SW-1:0] SLOT_LAST = SW'(CAPACITY - 1);

   logic [SW-1:0]       links [CAPACITY];
   logic [CAPACITY-1:0] written_ff;
   logic [SW-1:0]       link_rd_ff;
   logic                link_ok_ff;
   logic [SW-1:0]       rd_addr_ff;
   logic [SW-1:0]       dflt_link;

   // link memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         links[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         link_rd_ff <= links[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // written marks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         link_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            link_ok_ff <= written_ff[rd_addr];
         end
      end
   end

   // untouched slot links to its successor
   assign dflt_link = (rd_addr_ff == SLOT_LAST) ? '0 : rd_addr_ff + SW'(1);
   assign rd_data   = link_ok_ff ? link_rd_ff : dflt_link;

endmodule

// ===== hdl/bounded_linked_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_linked_list_engine - ordered list of signed values in a slot store
// Insert, append, delete-first-match and list over a linked store with a
// free chain, run by a small sequencer over one value and one link memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one command per transfer, req_tdata = {value, cmd}.
//   rsp channel: results, rsp_tdata = data, rsp_tuser = status, rsp_tlast
//   marks the final result of a command.
//   One command is in work at a time; req_tready is high only while the
//   sequencer is idle, and it returns in the same cycle as the final result
//   appears in the output register, even if that result is not yet
//   taken.
//   Steps to the (final) result register:
//     insert / append : allocate from free chain, then reply
//     delete          : walk to the first match, free its slot, then reply;
//                       reply at the end of the walk when no entry matches
//     list            : walk, one entry a cycle with no stall
//     full / empty    : reply directly, with no walk
//   The walk reads one slot a cycle from the value and link memories, so
//   delete and list are bound by the list length, up to CAPACITY entries.
//   A stalled receiver holds the output register; a list walk pauses until
//   the register frees. Reset empties the list and restores the free chain
//   at once: no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine
   import bll_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [1:0] cmd, [33:2] value, [39:34] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);

   state_type            state_ff, state_in;
   cmd_type              req_cmd;
   logic signed [31:0]   req_value;
   logic signed [31:0]   value_ff, value_in;
   logic [SW-1:0]        cur_ff, cur_in;
   logic [SW-1:0]        prev_ff, prev_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [SW-1:0]        head_ff, head_in;
   logic [SW-1:0]        tail_ff, tail_in;
   logic [SW-1:0]        free_ff, free_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 append_ff, append_in;
   logic [2:0]           pend_status_ff, pend_status_in;
   logic signed [31:0]   pend_data_ff, pend_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic signed [31:0]   rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic signed [31:0]   values [CAPACITY];
   logic signed [31:0]   val_rd_ff;
   logic                 val_we;
   logic                 rd_en;
   logic [SW-1:0]        rd_addr;
   logic                 link_we;
   logic [SW-1:0]        link_wa;
   logic [SW-1:0]        link_wd;
   logic [SW-1:0]        link_rd;

   logic                 req_xfer;
   logic                 out_free;
   logic [CW-1:0]        idx_nxt;
   logic                 idx_last;

   assign req_cmd   = cmd_type'(req_tdata[1:0]);
   assign req_value = req_tdata[33:2];
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_nxt   = idx_ff + CW'(1);
   assign idx_last  = (idx_nxt == count_ff);

   // value memory: written on allocation, registered read
   always_ff @(posedge clock) begin
      if (val_we) begin
         values[free_ff] <= req_value;
      end
      if (rd_en) begin
         val_rd_ff <= values[rd_addr];
      end
   end

   bll_link_store #(
      .CAPACITY (CAPACITY),
      .SW       (SW)
   ) u_links (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (link_rd)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      value_in       = value_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      idx_in         = idx_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      free_in        = free_ff;
      count_in       = count_ff;
      append_in      = append_ff;
      pend_status_in = pend_status_ff;
      pend_data_in   = pend_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      val_we         = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      link_we        = 1'b0;
      link_wa        = '0;
      link_wd        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               value_in     = req_value;
               append_in    = (req_cmd == CMD_APPEND);
               pend_data_in = '0;
               case (req_cmd)
                  CMD_INSERT, CMD_APPEND: begin
                     if (count_ff == COUNT_FULL) begin
                        pend_status_in = ST_FULL;
                        state_in       = S_REPLY;
                     end else begin
                        val_we   = 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = free_ff;
                        state_in = S_ALLOC;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        pend_status_in = ST_EMPTY;
                        state_in       = S_REPLY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        cur_in   = head_ff;
                        prev_in  = head_ff;
                        idx_in   = '0;
                        state_in = (req_cmd == CMD_DELETE) ? S_WALK : S_LIST;
                     end
                  end
               endcase
            end
         end

         // link in the slot taken from the free chain
         S_ALLOC: begin
            free_in = link_rd;
            if (count_ff == '0) begin
               head_in = free_ff;
               tail_in = free_ff;
            end else if (!append_ff) begin
               link_we = 1'b1;
               link_wa = free_ff;
               link_wd = head_ff;
               head_in = free_ff;
            end else begin
               link_we = 1'b1;
               link_wa = tail_ff;
               link_wd = free_ff;
               tail_in = free_ff;
            end
            count_in       = count_ff + CW'(1);
            pend_status_in = ST_DONE;
            state_in       = S_REPLY;
         end

         // compare one entry a cycle
         S_WALK: begin
            if (val_rd_ff == value_ff) begin
               if (idx_ff == '0) begin
                  head_in = link_rd;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff;
                  link_wd = link_rd;
                  if (cur_ff == tail_ff) begin
                     tail_in = prev_ff;
                  end
               end
               pend_data_in = val_rd_ff;
               state_in     = S_FREE;
            end else if (idx_last) begin
               pend_status_in = ST_NOTFOUND;
               state_in       = S_REPLY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = link_rd;
               prev_in = cur_ff;
               cur_in  = link_rd;
               idx_in  = idx_nxt;
            end
         end

         // return the unlinked slot to the free chain
         S_FREE: begin
            link_we        = 1'b1;
            link_wa        = cur_ff;
            link_wd        = free_ff;
            free_in        = cur_ff;
            count_in       = count_ff - CW'(1);
            pend_status_in = ST_DONE;
            state_in       = S_REPLY;
         end

         // one entry per free output slot
         S_LIST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LISTED;
               rsp_data_in   = val_rd_ff;
               rsp_last_in   = idx_last;
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = link_rd;
                  cur_in  = link_rd;
                  idx_in  = idx_nxt;
               end
            end
         end

         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_data_in   = pend_data_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff       <= value_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      idx_ff         <= idx_in;
      append_ff      <= append_in;
      pend_status_ff <= pend_status_in;
      pend_data_ff   <= pend_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/bll_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bll_checker - port-level checks of the linked list engine
// Watches the command and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bll_checker
   import bll_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // one command in work: no transfer straight after a transfer
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while another was in work");

   // every status other than a listed entry ends its command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_LISTED |-> rsp_tlast)
      else $error("single result without last mark");

   // failure statuses carry zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY ||
                     rsp_tuser == ST_NOTFOUND) |-> rsp_tdata == '0)
      else $error("failure status with non-zero data");

   // no new command while a list is still mid-stream
   a_list_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_LISTED && !rsp_tlast |-> !req_tready)
      else $error("ready while a list was unfinished");

endmodule

bind bounded_linked_list_engine bll_checker u_bll_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
